[src/assert_macros.svh]
// Assertion macros used by the calibrator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/tpc_pkg.sv]
// Types and constants of the touch position calibrator.
package tpc_pkg;

   localparam int POS_W      = 16;
   localparam int DIM_W      = 12;
   localparam int ACT_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [ACT_W-1:0] ACT_READ = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LOW  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_HIGH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_APPLY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [POS_W-1:0] BOUND_MAX      = 16'hffff;
   localparam logic [POS_W-1:0] OFFSET_X_RESET = 16'd6648;
   localparam logic [POS_W-1:0] OFFSET_Y_RESET = 16'd6689;
   localparam logic [POS_W-1:0] SCALE_X_RESET  = 16'd209;
   localparam logic [POS_W-1:0] SCALE_Y_RESET  = 16'd159;
   localparam logic [DIM_W-1:0] WIDTH_RESET    = 12'd240;
   localparam logic [DIM_W-1:0] HEIGHT_RESET   = 12'd320;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             pen_up;
      logic [POS_W-1:0] raw_x;
      logic [POS_W-1:0] raw_y;
   } req_type;

   typedef struct packed {
      logic             touched;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic             calib_done;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_SCALE,
      ST_HOLD
   } state_type;

endpackage

[src/touch_position_calibrator_unit.sv]
// Top level of the touch position calibrator: two-point calibration and mapping.
//
//   channel   direction  handshake               word
//   req_      in         req_valid / req_stall   req_type sample
//   rsp_      out        rsp_valid / rsp_stall   rsp_type result
//   csr_      in         csr_wen                 index and 12-bit data
//
// A pen-up sample bypasses the dividers; a pressed sample runs the X and Y serial
// dividers, 16 steps each, once for the position, and the sample that commits a
// high corner runs them once more for the scale.
// Reset is synchronous and restores the default offsets, scales and screen size.
// A result waits in the output register while the next sample is taken.
// rsp_stall holds only the final load of the output register.
`include "assert_macros.svh"

module touch_position_calibrator_unit #(
   parameter int CALIB_SAMPLES = 8,
   parameter int ADC_BITS      = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tpc_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tpc_pkg::rsp_type               rsp_payload,
   input  logic                           csr_wen,
   input  logic [tpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tpc_pkg::*;

   localparam logic [POS_W-1:0] ADC_MASK = POS_W'((32'd1 << ADC_BITS) - 32'd1);
   localparam int               CNT_W    = $clog2(CALIB_SAMPLES + 1);
   localparam logic [CNT_W:0]   SAMPLES_C = (CNT_W + 1)'(CALIB_SAMPLES);

   state_type state_ff, state_in;

   logic             apply_ff;
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [POS_W-1:0] offset_x_ff, offset_y_ff;
   logic [POS_W-1:0] scale_x_ff, scale_y_ff;
   logic [POS_W-1:0] bound_x_ff, bound_y_ff;
   logic [CNT_W-1:0] count_ff;
   logic             phase_high_ff;
   logic             commit_high_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             touched_ff, calib_done_ff, map_apply_ff;
   logic             below_x_ff, below_y_ff;
   logic [POS_W-1:0] raw_x_ff, raw_y_ff;
   logic [POS_W-1:0] pos_x_ff, pos_y_ff;

   logic             accept, pressed, is_calib, is_high, restart, commit;
   logic [POS_W-1:0] raw_x_m, raw_y_m;
   logic [POS_W-1:0] base_x, base_y, new_x, new_y;
   logic [CNT_W:0]   cnt_next;

   logic             div_start, map_load, scale_load, out_load;
   logic [POS_W-1:0] dividend_x, dividend_y, divisor_x, divisor_y;
   logic [POS_W-1:0] quo_x, quo_y;
   logic             div_done_x, div_done_y;

   assign accept  = req_valid && !req_stall;
   assign pressed = !req_payload.pen_up;
   assign raw_x_m = req_payload.raw_x & ADC_MASK;
   assign raw_y_m = req_payload.raw_y & ADC_MASK;

   always_comb begin
      is_calib = 1'b0;
      is_high  = 1'b0;
      unique case (req_payload.action)
         ACT_LOW: begin
            is_calib = 1'b1;
         end
         ACT_HIGH: begin
            is_calib = 1'b1;
            is_high  = 1'b1;
         end
         default: begin
            is_calib = 1'b0;
         end
      endcase
   end

   // restart the phase when idle or when the other corner shows up
   always_comb begin
      restart  = (count_ff == '0) || (phase_high_ff != is_high);
      base_x   = restart ? (is_high ? '0 : BOUND_MAX) : bound_x_ff;
      base_y   = restart ? (is_high ? '0 : BOUND_MAX) : bound_y_ff;
      if (is_high) begin
         new_x = (raw_x_m > base_x) ? raw_x_m : base_x;
         new_y = (raw_y_m > base_y) ? raw_y_m : base_y;
      end else begin
         new_x = (raw_x_m < base_x) ? raw_x_m : base_x;
         new_y = (raw_y_m < base_y) ? raw_y_m : base_y;
      end
      cnt_next = {1'b0, (restart ? {CNT_W{1'b0}} : count_ff)} + 1'b1;
      commit   = cnt_next >= SAMPLES_C;
   end

   // divider operands: position mapping on accept, scale derivation afterwards
   always_comb begin
      if (state_ff == ST_IDLE) begin
         dividend_x = raw_x_m - offset_x_ff;
         dividend_y = raw_y_m - offset_y_ff;
         divisor_x  = (scale_x_ff == '0) ? POS_W'(1) : scale_x_ff;
         divisor_y  = (scale_y_ff == '0) ? POS_W'(1) : scale_y_ff;
      end else begin
         dividend_x = (bound_x_ff > offset_x_ff) ? bound_x_ff - offset_x_ff : '0;
         dividend_y = (bound_y_ff > offset_y_ff) ? bound_y_ff - offset_y_ff : '0;
         divisor_x  = {{(POS_W - DIM_W){1'b0}},
                       ((width_ff == '0) ? DIM_W'(1) : width_ff)};
         divisor_y  = {{(POS_W - DIM_W){1'b0}},
                       ((height_ff == '0) ? DIM_W'(1) : height_ff)};
      end
   end

   tpc_serial_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_x),
      .divisor  (divisor_x),
      .quotient (quo_x),
      .done     (div_done_x)
   );

   tpc_serial_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_y),
      .divisor  (divisor_y),
      .quotient (quo_y),
      .done     (div_done_y)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = pressed ? ST_MAP : ST_HOLD;
            end
         end
         ST_MAP: begin
            if (div_done_x) begin
               state_in = commit_high_ff ? ST_SCALE : ST_HOLD;
            end
         end
         ST_SCALE: begin
            if (div_done_x) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      div_start  = 1'b0;
      map_load   = 1'b0;
      scale_load = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid && pressed;
         end
         ST_MAP: begin
            map_load  = div_done_x;
            div_start = div_done_x && commit_high_ff;
         end
         ST_SCALE: begin
            scale_load = div_done_x;
         end
         ST_HOLD: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         apply_ff       <= 1'b1;
         width_ff       <= WIDTH_RESET;
         height_ff      <= HEIGHT_RESET;
         offset_x_ff    <= OFFSET_X_RESET;
         offset_y_ff    <= OFFSET_Y_RESET;
         scale_x_ff     <= SCALE_X_RESET;
         scale_y_ff     <= SCALE_Y_RESET;
         bound_x_ff     <= BOUND_MAX;
         bound_y_ff     <= BOUND_MAX;
         count_ff       <= '0;
         phase_high_ff  <= 1'b0;
         commit_high_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_APPLY:  apply_ff  <= csr_wdata[0];
               CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
               CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
               default:    ;
            endcase
         end
         if (accept) begin
            commit_high_ff <= pressed && is_calib && commit && is_high;
            if (pressed && is_calib) begin
               phase_high_ff <= is_high;
               bound_x_ff    <= new_x;
               bound_y_ff    <= new_y;
               count_ff      <= commit ? '0 : cnt_next[CNT_W-1:0];
               if (commit && !is_high) begin
                  offset_x_ff <= new_x;
                  offset_y_ff <= new_y;
               end
            end
         end
         if (scale_load) begin
            scale_x_ff <= (quo_x == '0) ? POS_W'(1) : quo_x;
            scale_y_ff <= (quo_y == '0) ? POS_W'(1) : quo_y;
            apply_ff   <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         touched_ff    <= pressed;
         calib_done_ff <= pressed && is_calib && commit;
         map_apply_ff  <= apply_ff;
         raw_x_ff      <= raw_x_m;
         raw_y_ff      <= raw_y_m;
         below_x_ff    <= raw_x_m < offset_x_ff;
         below_y_ff    <= raw_y_m < offset_y_ff;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
      end
      // floor at zero below the offset, pass raw when mapping is off
      if (map_load) begin
         pos_x_ff <= !map_apply_ff ? raw_x_ff : (below_x_ff ? '0 : quo_x);
         pos_y_ff <= !map_apply_ff ? raw_y_ff : (below_y_ff ? '0 : quo_y);
      end
      if (out_load) begin
         rsp_ff.touched    <= touched_ff;
         rsp_ff.pos_x      <= pos_x_ff;
         rsp_ff.pos_y      <= pos_y_ff;
         rsp_ff.calib_done <= calib_done_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_ALWAYS(a_div_lockstep, clock, reset, div_done_x == div_done_y, "dividers out of step")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE, "accept left block idle")
   `ASSERT_IMPLIES(a_scale_nonzero, clock, reset, state_ff == ST_IDLE, scale_x_ff != '0 && scale_y_ff != '0, "zero scale stored")

endmodule

[src/tpc_serial_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module tpc_serial_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tpc_pkg::POS_W-1:0] dividend,
   input  logic [tpc_pkg::POS_W-1:0] divisor,
   output logic [tpc_pkg::POS_W-1:0] quotient,
   output logic                      done
);
   import tpc_pkg::*;

   localparam int CNT_W = $clog2(POS_W);

   logic [POS_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0] quo_ff, quo_in;
   logic [POS_W-1:0] div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [POS_W:0]   trial;
   logic [POS_W:0]   diff;
   logic             fits;

   // shift the next dividend bit into the partial remainder
   always_comb begin
      trial  = {rem_ff, quo_ff[POS_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? diff[POS_W-1:0] : trial[POS_W-1:0];
      quo_in = {quo_ff[POS_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(POS_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[tb/tb.sv]
// Self-checking testbench for the touch position calibrator: directed rows, then random phases.
module tb;
   import tpc_pkg::*;

   localparam int CALIB_SAMPLES = 8;
   localparam int ADC_BITS      = 16;
   localparam logic [POS_W-1:0] ADC_MASK = POS_W'((32'd1 << ADC_BITS) - 1);
   localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
   localparam int ITEM_TARGET = 550;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // typed-in expectation that rides along with the word on the request side
   logic fix_valid = 1'b0;
   rsp_type fix_word = '0;

   // predictor state
   logic cal_apply = 1'b1;
   logic [DIM_W-1:0] cal_width = WIDTH_RESET;
   logic [DIM_W-1:0] cal_height = HEIGHT_RESET;
   logic [POS_W-1:0] off_x = OFFSET_X_RESET;
   logic [POS_W-1:0] off_y = OFFSET_Y_RESET;
   logic [POS_W-1:0] scl_x = SCALE_X_RESET;
   logic [POS_W-1:0] scl_y = SCALE_Y_RESET;
   logic [POS_W-1:0] bnd_x = BOUND_MAX;
   logic [POS_W-1:0] bnd_y = BOUND_MAX;
   logic [7:0] taken = '0;
   logic tracking_high = 1'b0;

   rsp_type pending_touch[$];
   rsp_type want_word;
   int items_sent = 0;
   int results_seen = 0;
   int errors = 0;
   bit calm = 1'b0;

   typedef struct {
      bit                    csr_en;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      req_type               word;
      bit                    fixed;
      rsp_type               want;
   } script_row;

   script_row script[$];

   touch_position_calibrator_unit #(
      .CALIB_SAMPLES(CALIB_SAMPLES),
      .ADC_BITS(ADC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [POS_W-1:0] scaled_axis(logic [POS_W-1:0] raw,
                                                   logic [POS_W-1:0] off,
                                                   logic [POS_W-1:0] scl);
      logic [POS_W-1:0] d;
      d = (scl != 0) ? scl : POS_W'(1);
      if (!cal_apply) return raw;
      if (raw < off) return '0;
      return (raw - off) / d;
   endfunction

   function automatic logic [POS_W-1:0] corner_scale(logic [POS_W-1:0] maxv,
                                                    logic [POS_W-1:0] off,
                                                    logic [DIM_W-1:0] size);
      logic [POS_W-1:0] s;
      logic [POS_W-1:0] q;
      s = (size != 0) ? POS_W'(size) : POS_W'(1);
      q = (maxv > off) ? (maxv - off) / s : '0;
      if (q < 1) q = 1;
      return q;
   endfunction

   function automatic rsp_type predict_touch(req_type w);
      rsp_type r;
      logic [POS_W-1:0] rx;
      logic [POS_W-1:0] ry;
      bit hi;
      r = '0;
      rx = w.raw_x & ADC_MASK;
      ry = w.raw_y & ADC_MASK;
      if (w.pen_up) return r;
      r.touched = 1'b1;
      r.pos_x = scaled_axis(rx, off_x, scl_x);
      r.pos_y = scaled_axis(ry, off_y, scl_y);
      if (w.action == ACT_LOW || w.action == ACT_HIGH) begin
         hi = (w.action == ACT_HIGH);
         // restart tracking on a fresh phase or a corner switch
         if (taken == 0 || tracking_high != hi) begin
            tracking_high = hi;
            taken = '0;
            bnd_x = hi ? '0 : BOUND_MAX;
            bnd_y = hi ? '0 : BOUND_MAX;
         end
         if (hi) begin
            if (rx > bnd_x) bnd_x = rx;
            if (ry > bnd_y) bnd_y = ry;
         end else begin
            if (rx < bnd_x) bnd_x = rx;
            if (ry < bnd_y) bnd_y = ry;
         end
         taken = taken + 8'd1;
         if (taken >= CALIB_SAMPLES) begin
            if (hi) begin
               scl_x = corner_scale(bnd_x, off_x, cal_width);
               scl_y = corner_scale(bnd_y, off_y, cal_height);
               cal_apply = 1'b1;
            end else begin
               off_x = bnd_x;
               off_y = bnd_y;
            end
            taken = '0;
            r.calib_done = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic req_type make_req(logic [ACT_W-1:0] a, logic p,
                                        logic [POS_W-1:0] x, logic [POS_W-1:0] y);
      req_type w;
      w.action = a;
      w.pen_up = p;
      w.raw_x = x;
      w.raw_y = y;
      return w;
   endfunction

   function automatic logic [POS_W-1:0] rand_raw();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return BOUND_MAX;
         2: return POS_W'($urandom_range(0, 255));
         default: return POS_W'($urandom);
      endcase
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(0, 5))
         0: return 12'd1;
         1: return 12'd4095;
         2: return CSR_DATA_W'($urandom_range(1, 16));
         default: return CSR_DATA_W'($urandom_range(1, 4095));
      endcase
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("result %0d: %s got 0x%0h, want 0x%0h", results_seen, field, got, want);
      errors++;
   endtask

   task automatic add_row(input bit csr_en, input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] val, input logic [ACT_W-1:0] a,
                          input logic p, input logic [POS_W-1:0] x,
                          input logic [POS_W-1:0] y, input bit fixed, input logic t,
                          input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                          input logic done);
      script_row row;
      row.csr_en = csr_en;
      row.csr_idx = idx;
      row.csr_val = val;
      row.word = make_req(a, p, x, y);
      row.fixed = fixed;
      row.want.touched = t;
      row.want.pos_x = px;
      row.want.pos_y = py;
      row.want.calib_done = done;
      script.push_back(row);
   endtask

   task automatic send_sample(input req_type word, input bit fixed, input rsp_type want);
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= word;
      fix_valid <= fixed;
      fix_word <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_APPLY:  cal_apply = val[0];
         CSR_WIDTH:  cal_width = val;
         CSR_HEIGHT: cal_height = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one corner: pressed samples around a base, with pen-up noise, reads and corner switches
   task automatic run_corner(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] bx,
                             input logic [POS_W-1:0] by, input int spread);
      int n;
      int r;
      logic [ACT_W-1:0] other;
      n = 0;
      other = (act == ACT_LOW) ? ACT_HIGH : ACT_LOW;
      while (n < CALIB_SAMPLES) begin
         r = $urandom_range(0, 19);
         if (r < 2) begin
            send_sample(make_req(act, 1'b1, rand_raw(), rand_raw()), 1'b0, '0);
         end else if (r < 4) begin
            send_sample(make_req(ACT_READ, 1'b0, rand_raw(), rand_raw()), 1'b0, '0);
         end else if (r == 4) begin
            send_sample(make_req(other, 1'b0, rand_raw(), rand_raw()), 1'b0, '0);
            n = 0;
         end else begin
            send_sample(make_req(act, 1'b0, POS_W'(bx + $urandom_range(0, spread)),
                                 POS_W'(by + $urandom_range(0, spread))), 1'b0, '0);
            n++;
         end
      end
   endtask

   // result side: compare each word with the oldest expectation, then record new ones
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_touch.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_payload.pos_x), 0);
            end else begin
               want_word = pending_touch.pop_front();
               if (rsp_payload.touched !== want_word.touched)
                  report_mismatch("touched", rsp_payload.touched, want_word.touched);
               if (rsp_payload.pos_x !== want_word.pos_x)
                  report_mismatch("pos_x", rsp_payload.pos_x, want_word.pos_x);
               if (rsp_payload.pos_y !== want_word.pos_y)
                  report_mismatch("pos_y", rsp_payload.pos_y, want_word.pos_y);
               if (rsp_payload.calib_done !== want_word.calib_done)
                  report_mismatch("calib_done", rsp_payload.calib_done, want_word.calib_done);
            end
         end
         if (req_valid && !req_stall) begin
            want_word = predict_touch(req_payload);
            pending_touch.push_back(fix_valid ? fix_word : want_word);
         end
      end
   end

   // receiver back-pressure: short stalls mostly, a few long ones, none while calm
   initial begin
      int run;
      int stall;
      forever begin
         run = calm ? 50 : $urandom_range(1, 8);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         stall = calm ? 0 : idle_len();
         if (stall > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int kind;
      int n;
      int spread;
      logic [POS_W-1:0] lo_x;
      logic [POS_W-1:0] lo_y;
      logic [POS_W-1:0] hi_x;
      logic [POS_W-1:0] hi_y;

      // defaults after reset, extremes, undefined action
      add_row(0, CSR_APPLY, 0, ACT_READ, 1, 16'hffff, 16'hffff, 1, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_READ, 0, 16'h0000, 16'h0000, 1, 1, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_READ, 0, 16'hffff, 16'hffff, 1, 1, 281, 370, 0);
      add_row(0, CSR_APPLY, 0, ACT_UNDEF, 0, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
      // high corner started, then switched to low mid-phase
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'h9000, 16'ha000, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'ha000, 16'h9000, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2100, 16'h2300, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2000, 16'h2400, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2200, 16'h2200, 0, 0, 0, 0, 0);
      // read mid-phase keeps progress; pen up during calibration is ignored
      add_row(0, CSR_APPLY, 0, ACT_READ, 0, 16'h5000, 16'h6000, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 1, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2050, 16'h2380, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2300, 16'h2210, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2010, 16'h2500, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2400, 16'h2250, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_LOW, 0, 16'h2020, 16'h2220, 0, 0, 0, 0, 0);
      // high corner: zero width on X, Y maximum stays below its offset
      add_row(1, CSR_WIDTH, 0, ACT_HIGH, 0, 16'h3000, 16'h1000, 0, 0, 0, 0, 0);
      add_row(1, CSR_HEIGHT, 4095, ACT_HIGH, 0, 16'h8000, 16'h2100, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'hffff, 16'h0000, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'h4000, 16'h21ff, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'h9000, 16'h1800, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'h0000, 16'h2000, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'h7000, 16'h0100, 0, 0, 0, 0, 0);
      add_row(0, CSR_APPLY, 0, ACT_HIGH, 0, 16'hc000, 16'h1f00, 0, 0, 0, 0, 0);
      // raw pass-through
      add_row(1, CSR_APPLY, 0, ACT_READ, 0, 16'hffff, 16'hffff, 1, 1, 16'hffff, 16'hffff, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].csr_en) begin
            wait_idle();
            write_csr(script[i].csr_idx, script[i].csr_val);
         end
         send_sample(script[i].word, script[i].fixed, script[i].want);
      end

      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         if ($urandom_range(0, 2) == 0) write_csr(CSR_APPLY, CSR_DATA_W'($urandom_range(0, 1)));
         if ($urandom_range(0, 2) == 0) write_csr(CSR_WIDTH, pick_size());
         if ($urandom_range(0, 2) == 0) write_csr(CSR_HEIGHT, pick_size());
         calm = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            if ($urandom_range(0, 3) == 0) begin
               spread = 65535;
               lo_x = '0;
               lo_y = '0;
               hi_x = '0;
               hi_y = '0;
            end else begin
               spread = $urandom_range(0, 1500);
               lo_x = POS_W'($urandom_range(0, 20000));
               lo_y = POS_W'($urandom_range(0, 20000));
               hi_x = POS_W'($urandom_range(25000, 64000));
               hi_y = POS_W'($urandom_range(25000, 64000));
            end
            if ($urandom_range(0, 3) != 0) run_corner(ACT_LOW, lo_x, lo_y, spread);
            if ($urandom_range(0, 3) != 0) run_corner(ACT_HIGH, hi_x, hi_y, spread);
         end else begin
            n = $urandom_range(10, 30);
            repeat (n) begin
               if (kind < 8)
                  send_sample(make_req(ACT_READ, ($urandom_range(0, 7) == 0), rand_raw(),
                                       rand_raw()), 1'b0, '0);
               else
                  send_sample(make_req(ACT_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                       rand_raw(), rand_raw()), 1'b0, '0);
            end
         end
      end

      wait_idle();
      repeat (60) @(posedge clock);
      if (pending_touch.size() != 0)
         report_mismatch("results missing", 0, pending_touch.size());
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/tpc_pkg.sv
src/tpc_serial_div.sv
src/touch_position_calibrator_unit.sv
tb/tb.sv
